// File: sv/hfvl_pkg.sv
// Shared types, constants and fixed-point helpers of the hand follow velocity limiter.
// No dependencies; hfvl_lane and the top level import this package.
package hfvl_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 5;

	localparam logic [30:0] FOLLOW_GAIN_RST  = 31'd734003;
	localparam logic [30:0] HISTORY_GAIN_RST = 31'd209715;
	localparam logic [31:0] DEPTH_OFFSET_RST = 32'd209715;
	localparam logic [30:0] ACCEL_LIMIT_RST  = 31'd1048576;
	localparam logic [30:0] JERK_LIMIT_RST   = 31'd524288000;

	typedef enum logic [2:0] {
		CFG_FOLLOW_GAIN  = 3'd0,
		CFG_HISTORY_GAIN = 3'd1,
		CFG_DEPTH_OFFSET = 3'd2,
		CFG_ACCEL_LIMIT  = 3'd3,
		CFG_JERK_LIMIT   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] hand_x;
		logic signed [31:0] hand_y;
		logic signed [31:0] hand_z;
		logic               hand_valid;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic signed [31:0] acc_z;
		logic        [20:0] tick_period;
	} req_t;

	typedef struct packed {
		logic signed [31:0] cmd_x;
		logic signed [31:0] cmd_y;
		logic signed [31:0] cmd_z;
	} rsp_t;

	// registers every axis lane reads
	typedef struct packed {
		logic [30:0] follow_gain;
		logic [30:0] history_gain;
		logic [30:0] accel_limit;
		logic [30:0] jerk_limit;
	} lane_cfg_t;

	typedef struct packed {
		logic        start;
		logic        hand_valid;
		logic [20:0] tick_period;
	} lane_ctl_t;

	// drop 20 fraction bits, round to nearest with ties up
	function automatic logic signed [71:0] rnd20(input logic signed [71:0] v);
		rnd20 = (v + 72'sd524288) >>> 20;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		logic signed [31:0] r;
		if (v > 72'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -72'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: sv/hfvl_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module hfvl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 5,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/hfvl_div.sv
// Signed divide by a constant, truncating toward zero: the magnitude times a fixed-point
// reciprocal in two partial products, summed and shifted. No dependencies.
module hfvl_div #(
	parameter int unsigned DIVISOR    = 5,
	parameter int unsigned DIVIDEND_W = 36
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [DIVIDEND_W-1:0] dividend,
	output logic                         busy,
	output logic signed [DIVIDEND_W-1:0] quot
);

	// floor(n / D) == floor(n * ceil(2^S / D) / 2^S) for n < 2^MAG_W, S = MAG_W + clog2(D)
	localparam int unsigned MAG_W = DIVIDEND_W;
	localparam int unsigned SHIFT = MAG_W + $clog2(DIVISOR);
	localparam int unsigned M_W   = MAG_W + 1;
	localparam int unsigned LO_W  = (M_W + 1) / 2;
	localparam int unsigned HI_W  = M_W - LO_W;
	localparam int unsigned P_W   = MAG_W + M_W;
	localparam logic [63:0] RECIP =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
	localparam logic [HI_W-1:0] RECIP_HI = RECIP[M_W-1:LO_W];

	localparam logic [1:0] PH_LO   = 2'd3;
	localparam logic [1:0] PH_HI   = 2'd2;
	localparam logic [1:0] PH_QUOT = 2'd1;

	logic [MAG_W-1:0]      mag_in, mag_q, qm_q;
	logic                  neg_q;
	logic [1:0]            ph_q;
	logic [MAG_W+LO_W-1:0] lo_q;
	logic [MAG_W+HI_W-1:0] hi_q;
	logic [P_W-1:0]        full;

	assign mag_in = dividend[DIVIDEND_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);
	assign busy   = (ph_q != 2'd0);
	assign full   = P_W'(lo_q) + {hi_q, {LO_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= '0;
		end else if (start) begin
			ph_q <= PH_LO;
		end else if (busy) begin
			ph_q <= ph_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_in;
			neg_q <= dividend[DIVIDEND_W-1];
		end
		if (ph_q == PH_LO) begin
			lo_q <= (MAG_W + LO_W)'(mag_q) * (MAG_W + LO_W)'(RECIP_LO);
		end
		if (ph_q == PH_HI) begin
			hi_q <= (MAG_W + HI_W)'(mag_q) * (MAG_W + HI_W)'(RECIP_HI);
		end
		if (ph_q == PH_QUOT) begin
			qm_q <= MAG_W'(full >> SHIFT);
		end
	end

	assign quot = neg_q ? -$signed(qm_q) : $signed(qm_q);

endmodule

// File: sv/hfvl_lane.sv
// One axis: goal velocity from hand offset and history mean, history update, and
// the jerk/acceleration limited ramp. Depends on hfvl_pkg, hfvl_div, hfvl_ram.
module hfvl_lane #(
	parameter int unsigned HISTORY_DEPTH = hfvl_pkg::HISTORY_DEPTH_DEF,
	localparam int unsigned POS_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hfvl_pkg::lane_ctl_t   ctl,
	input  hfvl_pkg::lane_cfg_t   cfg,
	input  logic signed [32:0]    offset,
	input  logic signed [31:0]    vel,
	input  logic signed [31:0]    acc,
	input  logic [POS_W-1:0]      pos,
	input  logic                  hist_full,
	output logic                  done,
	output logic signed [31:0]    cmd
);
	import hfvl_pkg::*;

	localparam int unsigned SUM_W = 33 + $clog2(HISTORY_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_OFF, S_JRK, S_DIV, S_HIST, S_ACC, S_CMD
	} state_t;

	state_t state_q;
	logic   done_q;

	logic signed [32:0]       offset_q;
	logic signed [31:0]       vel_q, acc_q, goal_q, acc_new_q, cmd_q;
	logic [20:0]              t_q;
	logic                     valid_q;
	logic signed [SUM_W-1:0]  sum_q, quot;
	logic                     div_busy;
	logic signed [46:0]       fterm_q;
	logic signed [35:0]       dacc_q;
	logic signed [33:0]       diff_q;

	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic               mul_en;
	logic signed [64:0] prod_q;
	logic signed [71:0] rnd_prod, rnd_neg;

	logic signed [33:0] diff;
	logic signed [35:0] amax, ag, gap, acc_n;
	logic signed [31:0] scaled, hist_old, dv;
	logic [31:0]        rd_data;
	logic [33:0]        abs_diff, abs_dv;
	logic               hist_we;

	hfvl_div #(
		.DIVISOR   (HISTORY_DEPTH),
		.DIVIDEND_W(SUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.start && state_q == S_IDLE),
		.dividend(sum_q),
		.busy    (div_busy),
		.quot    (quot)
	);

	hfvl_ram #(
		.WIDTH(32),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (hist_we),
		.waddr(pos),
		.wdata(scaled),
		.raddr(pos),
		.rdata(rd_data)
	);

	// one shared multiplier, operands picked by phase
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		unique case (state_q)
			S_OFF: begin
				mul_a = offset_q;
				mul_b = $signed({1'b0, cfg.follow_gain});
			end
			S_JRK: begin
				mul_a = $signed({2'b00, cfg.jerk_limit});
				mul_b = $signed({11'd0, t_q});
			end
			S_HIST: begin
				mul_a = 33'(goal_q);
				mul_b = $signed({1'b0, cfg.history_gain});
			end
			S_ACC: begin
				mul_a = 33'(acc_new_q);
				mul_b = $signed({11'd0, t_q});
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign rnd_prod = rnd20(72'(prod_q));
	assign rnd_neg  = rnd20(-72'(prod_q));

	// acceleration step toward +/- accel_limit or zero, bounded by the jerk step
	always_comb begin
		diff = 34'(goal_q) - 34'(vel_q);
		amax = $signed({5'd0, cfg.accel_limit});
		if (diff > 34'sd0) begin
			ag = amax;
		end else if (diff < 34'sd0) begin
			ag = -amax;
		end else begin
			ag = '0;
		end
		gap = ag - 36'(acc_q);
		if (gap > dacc_q) begin
			acc_n = 36'(acc_q) + dacc_q;
		end else if (gap < -dacc_q) begin
			acc_n = 36'(acc_q) - dacc_q;
		end else begin
			acc_n = ag;
		end
	end

	assign scaled   = sat32(rnd_prod);
	assign dv       = sat32(rnd_prod);
	assign hist_old = hist_full ? $signed(rd_data) : 32'sd0;
	assign hist_we  = (state_q == S_ACC);
	assign abs_diff = diff_q[33] ? 34'(-diff_q) : 34'(diff_q);
	assign abs_dv   = dv[31] ? 34'(-34'(dv)) : 34'(dv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (ctl.start) begin
					state_q <= S_OFF;
				end
				S_OFF:  state_q <= S_JRK;
				S_JRK:  state_q <= S_DIV;
				S_DIV:  if (!div_busy) begin
					state_q <= S_HIST;
				end
				S_HIST: state_q <= S_ACC;
				S_ACC:  state_q <= S_CMD;
				S_CMD: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (state_q == S_ACC) begin
			sum_q <= sum_q - SUM_W'(hist_old) + SUM_W'(scaled);
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == S_IDLE && ctl.start) begin
			offset_q <= offset;
			vel_q    <= vel;
			acc_q    <= acc;
			t_q      <= ctl.tick_period;
			valid_q  <= ctl.hand_valid;
		end
		if (state_q == S_JRK) begin
			fterm_q <= rnd_neg[46:0];
		end
		if (state_q == S_DIV) begin
			dacc_q <= rnd_prod[35:0];
			goal_q <= valid_q ? sat32(72'(fterm_q) + 72'(quot)) : 32'sd0;
		end
		if (state_q == S_HIST) begin
			diff_q    <= diff;
			acc_new_q <= sat32(72'(acc_n));
		end
		if (state_q == S_CMD) begin
			cmd_q <= (abs_diff > abs_dv) ? sat32(72'(vel_q) + 72'(dv)) : goal_q;
		end
	end

	assign done = done_q;
	assign cmd  = cmd_q;

endmodule

// File: sv/hand_follow_velocity_limiter.sv
// Top level of the hand follow velocity limiter: three axis lanes and the result merge.
// Depends on hfvl_pkg and hfvl_lane.
//
// Usage:
//   req channel: one beat per control tick (hand offset, hand_valid, velocity,
//   acceleration, tick_period). Taken at an edge with req_valid high and
//   req_stall low. rsp channel: one beat of three commands per request.
//   cfg channel: register writes, cfg_ready is always high; write only while idle.
//   Three lanes (x from hand_y, y from hand_x, z from hand_z minus depth_offset)
//   run side by side, each with one shared 33x32 multiplier and a two-part
//   reciprocal multiply for the history mean.
//   After acceptance the history mean (overlapped with the offset and jerk
//   products) sets the goal, then the history, acceleration and command steps
//   run, and the result is loaded into the rsp register.
//   No new request is taken while one is in flight: req_stall stays high
//   from acceptance until the result enters the rsp register.
//   A finished result waits in the rsp register under rsp_stall; the next
//   request is already accepted, and its result is held in the lanes until
//   the register frees.
//   Reset clears the histories (by a fill flag), the sums and the write position,
//   and loads the register defaults.
module hand_follow_velocity_limiter #(
	parameter int unsigned HISTORY_DEPTH = hfvl_pkg::HISTORY_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  hfvl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output hfvl_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data
);
	import hfvl_pkg::*;

	localparam int unsigned POS_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	lane_cfg_t          cfg_q;
	logic signed [31:0] depth_offset_q;
	logic               busy_q, pend_q, rsp_valid_q, full_q;
	logic [POS_W-1:0]   pos_q;
	rsp_t               rsp_q;

	lane_ctl_t          ctl;
	logic               accept, res_rdy, load;
	logic [2:0]         lane_done;
	logic signed [31:0] cmd [3];
	logic signed [32:0] off_z;

	assign cfg_ready = 1'b1;
	assign req_stall = busy_q;
	assign accept    = req_valid && !busy_q;
	assign res_rdy   = (&lane_done) || pend_q;
	assign load      = res_rdy && (!rsp_valid_q || !rsp_stall);

	assign ctl.start       = accept;
	assign ctl.hand_valid  = req.hand_valid;
	assign ctl.tick_period = req.tick_period;
	assign off_z = 33'(req.hand_z) - 33'(depth_offset_q);

	hfvl_lane #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .cfg(cfg_q),
		.offset(33'(req.hand_y)), .vel(req.vel_x), .acc(req.acc_x),
		.pos(pos_q), .hist_full(full_q), .done(lane_done[0]), .cmd(cmd[0])
	);

	hfvl_lane #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .cfg(cfg_q),
		.offset(33'(req.hand_x)), .vel(req.vel_y), .acc(req.acc_y),
		.pos(pos_q), .hist_full(full_q), .done(lane_done[1]), .cmd(cmd[1])
	);

	hfvl_lane #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_lane_z (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .cfg(cfg_q),
		.offset(off_z), .vel(req.vel_z), .acc(req.acc_z),
		.pos(pos_q), .hist_full(full_q), .done(lane_done[2]), .cmd(cmd[2])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.follow_gain  <= FOLLOW_GAIN_RST;
			cfg_q.history_gain <= HISTORY_GAIN_RST;
			cfg_q.accel_limit  <= ACCEL_LIMIT_RST;
			cfg_q.jerk_limit   <= JERK_LIMIT_RST;
			depth_offset_q     <= DEPTH_OFFSET_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FOLLOW_GAIN:  cfg_q.follow_gain  <= cfg_data[30:0];
				CFG_HISTORY_GAIN: cfg_q.history_gain <= cfg_data[30:0];
				CFG_DEPTH_OFFSET: depth_offset_q     <= cfg_data;
				CFG_ACCEL_LIMIT:  cfg_q.accel_limit  <= cfg_data[30:0];
				CFG_JERK_LIMIT:   cfg_q.jerk_limit   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// shared history write position; full once every entry has been written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
		end else if (&lane_done) begin
			if (pos_q == POS_W'(HISTORY_DEPTH - 1)) begin
				pos_q  <= '0;
				full_q <= 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end
			if (load) begin
				busy_q      <= 1'b0;
				pend_q      <= 1'b0;
				rsp_valid_q <= 1'b1;
			end else begin
				if (res_rdy) begin
					pend_q <= 1'b1;
				end
				if (rsp_valid_q && !rsp_stall) begin
					rsp_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.cmd_x <= cmd[0];
			rsp_q.cmd_y <= cmd[1];
			rsp_q.cmd_z <= cmd[2];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
